// File: rtl/assert_macros.svh
// Assertion macros for the blob moments RTL, used by bbm_queue.
// No dependencies; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// File: rtl/bbm_pkg.sv
// Package for the binary blob moments block: widths, codes and types.
// No dependencies.
`timescale 1ns / 1ps
package bbm_pkg;
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    localparam int CFG_W   = 11;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_W-1:0] WIDTH_RST  = 11'd320;
    localparam logic [CFG_W-1:0] HEIGHT_RST = 11'd240;

    localparam int PIX_W   = 8;
    localparam int CNT_W   = 21;
    localparam int MEAN_W  = 18;
    localparam int VAR_W   = 27;
    localparam int COV_W   = 28;
    localparam int AREA_W  = 27;

    // iterative arithmetic unit
    localparam int AW     = 64;        // operand / result width
    localparam int DVD_W  = AW + 8;    // dividend carries 8 fraction bits
    localparam int ROOT_W = AW / 2;
    localparam logic [AW-1:0] AREA_BIAS = 64'd6554;

    typedef logic [1:0] t_arith_op;
    localparam t_arith_op OP_MUL  = 2'd0;
    localparam t_arith_op OP_DIV  = 2'd1;
    localparam t_arith_op OP_SQRT = 2'd2;

    typedef struct packed {
        logic      start;
        t_arith_op op;
    } t_arith_req;
endpackage

// File: rtl/bbm_front.sv
// Front end: raster counters, size registers and moment accumulators.
// Depends on bbm_pkg.
`timescale 1ns / 1ps
module bbm_front #(
    parameter int MAX_WIDTH  = bbm_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bbm_pkg::MAX_HEIGHT_DEF,
    parameter int SNAP_W     = 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [bbm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bbm_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                         i_accept,
    input  logic [bbm_pkg::PIX_W-1:0]    i_pixel,
    output logic                         o_push,
    output logic [SNAP_W-1:0]            o_snap
);
    import bbm_pkg::*;

    localparam int XW   = $clog2(MAX_WIDTH);
    localparam int YW   = $clog2(MAX_HEIGHT);
    localparam int NW   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int SXW  = NW + XW;
    localparam int SYW  = NW + YW;
    localparam int SXXW = NW + 2 * XW;
    localparam int SXYW = NW + XW + YW;
    localparam int SYYW = NW + 2 * YW;
    localparam int WC   = (XW + 1 > CFG_W) ? XW + 1 : CFG_W;
    localparam int HC   = (YW + 1 > CFG_W) ? YW + 1 : CFG_W;

    logic [CFG_W-1:0] r_width, r_height;
    logic [XW-1:0]    r_x;
    logic [YW-1:0]    r_y;
    logic [NW-1:0]    r_n, n_n;
    logic [SXW-1:0]   r_sx, n_sx;
    logic [SYW-1:0]   r_sy, n_sy;
    logic [SXXW-1:0]  r_sxx, n_sxx;
    logic [SXYW-1:0]  r_sxy, n_sxy;
    logic [SYYW-1:0]  r_syy, n_syy;
    logic [WC-1:0]    w_eff;
    logic [HC-1:0]    h_eff;
    logic             last_col, last_row, hit;

    always_comb begin
        if (r_width == '0) w_eff = WC'(1);
        else if (WC'(r_width) > WC'(MAX_WIDTH)) w_eff = WC'(MAX_WIDTH);
        else w_eff = WC'(r_width);
        if (r_height == '0) h_eff = HC'(1);
        else if (HC'(r_height) > HC'(MAX_HEIGHT)) h_eff = HC'(MAX_HEIGHT);
        else h_eff = HC'(r_height);
    end

    assign last_col = (WC'(r_x) + WC'(1)) >= w_eff;
    assign last_row = (HC'(r_y) + HC'(1)) >= h_eff;
    assign hit      = (i_pixel != '0);

    always_comb begin
        n_n   = r_n;
        n_sx  = r_sx;
        n_sy  = r_sy;
        n_sxx = r_sxx;
        n_sxy = r_sxy;
        n_syy = r_syy;
        if (hit) begin
            n_n   = r_n + NW'(1);
            n_sx  = r_sx + SXW'(r_x);
            n_sy  = r_sy + SYW'(r_y);
            n_sxx = r_sxx + SXXW'(r_x) * SXXW'(r_x);
            n_sxy = r_sxy + SXYW'(r_x) * SXYW'(r_y);
            n_syy = r_syy + SYYW'(r_y) * SYYW'(r_y);
        end
    end

    assign o_push = i_accept && last_col && last_row;
    assign o_snap = SNAP_W'({n_n, n_sx, n_sy, n_sxx, n_sxy, n_syy});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
            r_x      <= '0;
            r_y      <= '0;
            r_n      <= '0;
            r_sx     <= '0;
            r_sy     <= '0;
            r_sxx    <= '0;
            r_sxy    <= '0;
            r_syy    <= '0;
        end else begin
            if (i_cfg_we && i_cfg_idx == REG_WIDTH) r_width <= i_cfg_data;
            if (i_cfg_we && i_cfg_idx == REG_HEIGHT) r_height <= i_cfg_data;
            if (i_accept) begin
                if (!last_col) begin
                    r_x <= r_x + XW'(1);
                end else begin
                    r_x <= '0;
                    r_y <= last_row ? '0 : r_y + YW'(1);
                end
                if (o_push) begin
                    r_n   <= '0;
                    r_sx  <= '0;
                    r_sy  <= '0;
                    r_sxx <= '0;
                    r_sxy <= '0;
                    r_syy <= '0;
                end else begin
                    r_n   <= n_n;
                    r_sx  <= n_sx;
                    r_sy  <= n_sy;
                    r_sxx <= n_sxx;
                    r_sxy <= n_sxy;
                    r_syy <= n_syy;
                end
            end
        end
    end
endmodule

// File: rtl/bbm_queue.sv
// Two-entry queue of frame sums between front and back end.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bbm_queue #(
    parameter int DW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [DW-1:0] i_data,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output logic [DW-1:0] o_data
);
    logic [DW-1:0] r_mem [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    `ASSERT_RST(a_no_overflow, i_clk, i_rst_n, !(i_push && o_full && !i_pop), "queue overflow")
    `ASSERT_RST(a_no_underflow, i_clk, i_rst_n, !(i_pop && !o_valid), "queue underflow")
    `ASSERT_RST(a_cnt_range, i_clk, i_rst_n, r_cnt != 2'd3, "queue count out of range")
    `ASSERT_RST(a_cnt_track, i_clk, i_rst_n, (i_push && !i_pop) |=> (r_cnt == $past(r_cnt) + 2'd1), "count not incremented")
endmodule

// File: rtl/bbm_arith.sv
// Shared iterative unit: shift-add multiply, restoring divide, integer root.
// Depends on bbm_pkg.
`timescale 1ns / 1ps
module bbm_arith (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  bbm_pkg::t_arith_req       i_req,
    input  logic [bbm_pkg::DVD_W-1:0] i_a,
    input  logic [bbm_pkg::AW-1:0]    i_b,
    output logic                      o_done,
    output logic [bbm_pkg::AW-1:0]    o_result
);
    import bbm_pkg::*;

    localparam int ITW = $clog2(DVD_W);

    logic            r_busy, r_done;
    t_arith_op       r_op;
    logic [ITW-1:0]  r_cnt;
    logic [AW-1:0]   r_acc, r_ma, r_mb;
    logic [AW:0]     r_rem;
    logic [DVD_W-1:0] r_dq;
    logic [ROOT_W-1:0] r_root;
    logic [ROOT_W+3:0] r_srem;
    logic [AW-1:0]   r_sv;

    logic [AW:0]       rem_sh;
    logic              div_ge;
    logic [ROOT_W+3:0] srem_sh, trial;
    logic              sq_ge;

    assign rem_sh  = {r_rem[AW-1:0], r_dq[DVD_W-1]};
    assign div_ge  = rem_sh >= {1'b0, r_mb};
    assign srem_sh = {r_srem[ROOT_W+1:0], r_sv[AW-1:AW-2]};
    assign trial   = {2'b00, r_root, 2'b01};
    assign sq_ge   = srem_sh >= trial;

    always_comb begin
        case (r_op)
            OP_MUL:  o_result = r_acc;
            OP_DIV:  o_result = r_dq[AW-1:0];
            OP_SQRT: o_result = AW'(r_root);
            default: o_result = '0;
        endcase
    end
    assign o_done = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= OP_MUL;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (!r_busy && i_req.start) begin
                r_busy <= 1'b1;
                r_op   <= i_req.op;
                case (i_req.op)
                    OP_DIV:  r_cnt <= ITW'(DVD_W - 1);
                    OP_SQRT: r_cnt <= ITW'(ROOT_W - 1);
                    default: r_cnt <= ITW'(AW - 1);
                endcase
            end else if (r_busy) begin
                r_cnt <= r_cnt - ITW'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge i_clk) begin
        if (!r_busy && i_req.start) begin
            r_acc  <= '0;
            r_ma   <= i_a[AW-1:0];
            r_mb   <= i_b;
            r_rem  <= '0;
            r_dq   <= i_a;
            r_root <= '0;
            r_srem <= '0;
            r_sv   <= i_a[AW-1:0];
        end else if (r_busy) begin
            case (r_op)
                OP_MUL: begin
                    if (r_mb[0]) r_acc <= r_acc + r_ma;
                    r_ma <= {r_ma[AW-2:0], 1'b0};
                    r_mb <= {1'b0, r_mb[AW-1:1]};
                end
                OP_DIV: begin
                    r_rem <= div_ge ? rem_sh - {1'b0, r_mb} : rem_sh;
                    r_dq  <= {r_dq[DVD_W-2:0], div_ge};
                end
                OP_SQRT: begin
                    r_srem <= sq_ge ? srem_sh - trial : srem_sh;
                    r_root <= {r_root[ROOT_W-2:0], sq_ge};
                    r_sv   <= {r_sv[AW-3:0], 2'b00};
                end
                default: begin
                    r_acc <= r_acc;
                end
            endcase
        end
    end
endmodule

// File: rtl/bbm_back.sv
// Back end: sequences the frame-end arithmetic and holds the result register.
// Depends on bbm_pkg and bbm_arith.
`timescale 1ns / 1ps
module bbm_back #(
    parameter int MAX_WIDTH  = bbm_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bbm_pkg::MAX_HEIGHT_DEF,
    parameter int SNAP_W     = 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_q_valid,
    input  logic [SNAP_W-1:0]         i_q_data,
    output logic                      o_q_pop,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic                      o_found,
    output logic [bbm_pkg::CNT_W-1:0]  o_pixel_count,
    output logic [bbm_pkg::MEAN_W-1:0] o_mean_x_q,
    output logic [bbm_pkg::MEAN_W-1:0] o_mean_y_q,
    output logic [bbm_pkg::VAR_W-1:0]  o_var_x_q,
    output logic [bbm_pkg::VAR_W-1:0]  o_var_y_q,
    output logic signed [bbm_pkg::COV_W-1:0] o_cov_xy_q,
    output logic [bbm_pkg::AREA_W-1:0] o_area_q
);
    import bbm_pkg::*;

    localparam int XW   = $clog2(MAX_WIDTH);
    localparam int YW   = $clog2(MAX_HEIGHT);
    localparam int NW   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int SXW  = NW + XW;
    localparam int SYW  = NW + YW;
    localparam int SXXW = NW + 2 * XW;
    localparam int SXYW = NW + XW + YW;
    localparam int SYYW = NW + 2 * YW;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ISSUE = 2'd1;
    localparam logic [1:0] S_WAIT  = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    localparam logic [3:0] ST_NN    = 4'd0;
    localparam logic [3:0] ST_MX    = 4'd1;
    localparam logic [3:0] ST_MY    = 4'd2;
    localparam logic [3:0] ST_XX_A  = 4'd3;
    localparam logic [3:0] ST_XX_B  = 4'd4;
    localparam logic [3:0] ST_VX    = 4'd5;
    localparam logic [3:0] ST_YY_A  = 4'd6;
    localparam logic [3:0] ST_YY_B  = 4'd7;
    localparam logic [3:0] ST_VY    = 4'd8;
    localparam logic [3:0] ST_XY_A  = 4'd9;
    localparam logic [3:0] ST_XY_B  = 4'd10;
    localparam logic [3:0] ST_COV   = 4'd11;
    localparam logic [3:0] ST_DET_A = 4'd12;
    localparam logic [3:0] ST_DET_B = 4'd13;
    localparam logic [3:0] ST_AREA  = 4'd14;

    logic [1:0]    r_state;
    logic [3:0]    r_step;
    logic          r_found, r_cneg;
    logic [NW-1:0]   r_n;
    logic [SXW-1:0]  r_sx;
    logic [SYW-1:0]  r_sy;
    logic [SXXW-1:0] r_sxx;
    logic [SXYW-1:0] r_sxy;
    logic [SYYW-1:0] r_syy;
    logic [AW-1:0] r_nn, r_mx, r_my, r_ta, r_tb, r_vx, r_vy, r_cmag, r_area;

    logic [NW-1:0]   q_n;
    logic [SXW-1:0]  q_sx;
    logic [SYW-1:0]  q_sy;
    logic [SXXW-1:0] q_sxx;
    logic [SXYW-1:0] q_sxy;
    logic [SYYW-1:0] q_syy;

    t_arith_req       req;
    logic [DVD_W-1:0] op_a;
    logic [AW-1:0]    op_b, diff, adiff, res;
    logic             done, out_free, ab_ge;

    assign {q_n, q_sx, q_sy, q_sxx, q_sxy, q_syy} = i_q_data;

    assign ab_ge = r_ta >= r_tb;
    assign diff  = ab_ge ? r_ta - r_tb : '0;
    assign adiff = ab_ge ? r_ta - r_tb : r_tb - r_ta;

    always_comb begin
        req.start = (r_state == S_ISSUE);
        req.op    = OP_MUL;
        op_a      = '0;
        op_b      = '0;
        case (r_step)
            ST_NN: begin
                op_a = DVD_W'(r_n);   op_b = AW'(r_n);
            end
            ST_MX: begin
                req.op = OP_DIV; op_a = DVD_W'({r_sx, 8'h00}); op_b = AW'(r_n);
            end
            ST_MY: begin
                req.op = OP_DIV; op_a = DVD_W'({r_sy, 8'h00}); op_b = AW'(r_n);
            end
            ST_XX_A: begin
                op_a = DVD_W'(r_n);   op_b = AW'(r_sxx);
            end
            ST_XX_B: begin
                op_a = DVD_W'(r_sx);  op_b = AW'(r_sx);
            end
            ST_YY_A: begin
                op_a = DVD_W'(r_n);   op_b = AW'(r_syy);
            end
            ST_YY_B: begin
                op_a = DVD_W'(r_sy);  op_b = AW'(r_sy);
            end
            ST_XY_A: begin
                op_a = DVD_W'(r_n);   op_b = AW'(r_sxy);
            end
            ST_XY_B: begin
                op_a = DVD_W'(r_sx);  op_b = AW'(r_sy);
            end
            ST_VX, ST_VY: begin
                req.op = OP_DIV; op_a = {diff, 8'h00}; op_b = r_nn;
            end
            ST_COV: begin
                req.op = OP_DIV; op_a = {adiff, 8'h00}; op_b = r_nn;
            end
            ST_DET_A: begin
                op_a = DVD_W'(r_vx);  op_b = r_vy;
            end
            ST_DET_B: begin
                op_a = DVD_W'(r_cmag); op_b = r_cmag;
            end
            ST_AREA: begin
                req.op = OP_SQRT; op_a = DVD_W'(diff + AREA_BIAS);
            end
            default: begin
                req.op = OP_MUL;
            end
        endcase
    end

    bbm_arith u_arith (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (req),
        .i_a      (op_a),
        .i_b      (op_b),
        .o_done   (done),
        .o_result (res)
    );

    assign o_q_pop  = (r_state == S_IDLE) && i_q_valid;
    assign out_free = !o_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= ST_NN;
            o_valid <= 1'b0;
        end else begin
            if (r_state == S_DONE && out_free) o_valid <= 1'b1;
            else if (!i_stall) o_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_step  <= ST_NN;
                        r_state <= (q_n == '0) ? S_DONE : S_ISSUE;
                    end
                end
                S_ISSUE: r_state <= S_WAIT;
                S_WAIT: begin
                    if (done) begin
                        r_step  <= r_step + 4'd1;
                        r_state <= (r_step == ST_AREA) ? S_DONE : S_ISSUE;
                    end
                end
                S_DONE: begin
                    if (out_free) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_n     <= q_n;
            r_sx    <= q_sx;
            r_sy    <= q_sy;
            r_sxx   <= q_sxx;
            r_sxy   <= q_sxy;
            r_syy   <= q_syy;
            r_found <= (q_n != '0);
        end
        if (r_state == S_WAIT && done) begin
            case (r_step)
                ST_NN:    r_nn <= res;
                ST_MX:    r_mx <= res;
                ST_MY:    r_my <= res;
                ST_VX:    r_vx <= res;
                ST_VY:    r_vy <= res;
                ST_COV: begin
                    r_cmag <= res;
                    r_cneg <= !ab_ge;
                end
                ST_AREA:  r_area <= res;
                ST_XX_B, ST_YY_B, ST_XY_B, ST_DET_B: r_tb <= res;
                default:  r_ta <= res;
            endcase
        end
        if (r_state == S_DONE && out_free) begin
            o_found       <= r_found;
            o_pixel_count <= r_found ? CNT_W'(r_n) : '0;
            o_mean_x_q    <= r_found ? r_mx[MEAN_W-1:0] : '0;
            o_mean_y_q    <= r_found ? r_my[MEAN_W-1:0] : '0;
            o_var_x_q     <= r_found ? r_vx[VAR_W-1:0] : '0;
            o_var_y_q     <= r_found ? r_vy[VAR_W-1:0] : '0;
            o_cov_xy_q    <= !r_found ? '0 :
                             r_cneg ? COV_W'(AW'(0) - r_cmag) : r_cmag[COV_W-1:0];
            o_area_q      <= r_found ? r_area[AREA_W-1:0] : '0;
        end
    end
endmodule

// File: rtl/binary_blob_moments_core.sv
// Binary blob moments: accumulates pixel moments per frame, reports stats.
// Pixels: one per cycle; stall only while two finished frames await the back end.
// The result of a frame is computed after its last pixel by the
// shared shift-add multiplier, restoring divider and root unit.
// Empty frame: skips the arithmetic. Synchronous active-low reset clears
// counters, sums, queue and sequencer; size registers return to 320 x 240.
`timescale 1ns / 1ps
module binary_blob_moments_core #(
    parameter int MAX_WIDTH  = bbm_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bbm_pkg::MAX_HEIGHT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bbm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bbm_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [bbm_pkg::PIX_W-1:0]     i_pixel,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_found,
    output logic [bbm_pkg::CNT_W-1:0]     o_pixel_count,
    output logic [bbm_pkg::MEAN_W-1:0]    o_mean_x_q,
    output logic [bbm_pkg::MEAN_W-1:0]    o_mean_y_q,
    output logic [bbm_pkg::VAR_W-1:0]     o_var_x_q,
    output logic [bbm_pkg::VAR_W-1:0]     o_var_y_q,
    output logic signed [bbm_pkg::COV_W-1:0] o_cov_xy_q,
    output logic [bbm_pkg::AREA_W-1:0]    o_area_q
);
    import bbm_pkg::*;

    localparam int XW     = $clog2(MAX_WIDTH);
    localparam int YW     = $clog2(MAX_HEIGHT);
    localparam int NW     = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int SNAP_W = 6 * NW + 4 * XW + 4 * YW;

    logic              push, pop, full, q_valid, accept;
    logic [SNAP_W-1:0] snap, q_data;

    assign o_stall = full;
    assign accept  = i_valid && !full;

    bbm_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT),
        .SNAP_W    (SNAP_W)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_pixel    (i_pixel),
        .o_push     (push),
        .o_snap     (snap)
    );

    bbm_queue #(.DW(SNAP_W)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (snap),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    bbm_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT),
        .SNAP_W    (SNAP_W)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_data      (q_data),
        .o_q_pop       (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_found       (o_found),
        .o_pixel_count (o_pixel_count),
        .o_mean_x_q    (o_mean_x_q),
        .o_mean_y_q    (o_mean_y_q),
        .o_var_x_q     (o_var_x_q),
        .o_var_y_q     (o_var_y_q),
        .o_cov_xy_q    (o_cov_xy_q),
        .o_area_q      (o_area_q)
    );
endmodule

// File: verif/binary_blob_moments_core_tb.sv
// Self-checking testbench for binary_blob_moments_core: raster frames in, one stats result per frame.
// Depends on bbm_pkg and the core RTL; carries its own moment predictor and result checker.
`timescale 1ns / 1ps
module binary_blob_moments_core_tb;
    import bbm_pkg::*;

    localparam int DRAIN_CYCLES = 1200;
    localparam int CYCLE_LIMIT  = 20000000;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd2;

    typedef struct packed {
        logic              found;
        logic [CNT_W-1:0]  count;
        logic [MEAN_W-1:0] mean_x;
        logic [MEAN_W-1:0] mean_y;
        logic [VAR_W-1:0]  var_x;
        logic [VAR_W-1:0]  var_y;
        logic [COV_W-1:0]  cov_xy;
        logic [AREA_W-1:0] area;
    } blob_stats_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_W-1:0]      i_cfg_data = '0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [PIX_W-1:0]      i_pixel = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic                  o_found;
    logic [CNT_W-1:0]      o_pixel_count;
    logic [MEAN_W-1:0]     o_mean_x_q, o_mean_y_q;
    logic [VAR_W-1:0]      o_var_x_q, o_var_y_q;
    logic signed [COV_W-1:0] o_cov_xy_q;
    logic [AREA_W-1:0]     o_area_q;

    binary_blob_moments_core uut (.*);

    always #1 i_clk = ~i_clk;

    // predictor state
    longint unsigned frame_w, frame_h;
    longint unsigned col, row, hits, sx, sy, sxx, sxy, syy;
    blob_stats_t expected_stats[$];
    int  frames_done;
    int  pixels_sent;
    int  mismatches;
    int  cycles;
    bit  quiet;

    function automatic longint unsigned frac_div(longint unsigned num, longint unsigned den);
        return ((num / den) << 8) + (((num % den) << 8) / den);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned clamp_dim(longint unsigned v, longint unsigned maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    task automatic clear_sums();
        col = 0; row = 0; hits = 0;
        sx = 0; sy = 0; sxx = 0; sxy = 0; syy = 0;
    endtask

    task automatic accumulate_pixel(logic [PIX_W-1:0] pix);
        longint unsigned w, h, n, nn, a, b, vx, vy, cm, det;
        bit neg;
        blob_stats_t s;
        w = clamp_dim(frame_w, MAX_WIDTH_DEF);
        h = clamp_dim(frame_h, MAX_HEIGHT_DEF);
        if (pix != 0) begin
            hits++; sx += col; sy += row;
            sxx += col * col; sxy += col * row; syy += row * row;
        end
        if (col + 1 < w) begin
            col++;
            return;
        end
        col = 0;
        if (row + 1 < h) begin
            row++;
            return;
        end
        s = '0;
        n = hits;
        if (n != 0) begin
            nn = n * n;
            s.found = 1'b1;
            s.count = n[CNT_W-1:0];
            a = (sx << 8) / n; s.mean_x = a[MEAN_W-1:0];
            a = (sy << 8) / n; s.mean_y = a[MEAN_W-1:0];
            a = n * sxx; b = sx * sx;
            vx = frac_div(a >= b ? a - b : 0, nn);
            a = n * syy; b = sy * sy;
            vy = frac_div(a >= b ? a - b : 0, nn);
            a = n * sxy; b = sx * sy;
            neg = b > a;
            cm = frac_div(neg ? b - a : a - b, nn);
            s.var_x = vx[VAR_W-1:0];
            s.var_y = vy[VAR_W-1:0];
            a = neg ? (64'd0 - cm) : cm;
            s.cov_xy = a[COV_W-1:0];
            a = vx * vy; b = cm * cm;
            det = (a > b) ? a - b : 0;
            a = int_sqrt(det + 64'd6554);
            s.area = a[AREA_W-1:0];
        end
        expected_stats.push_back(s);
        frames_done++;
        clear_sums();
    endtask

    // output side: random stall plus the checker
    always @(posedge i_clk) begin
        blob_stats_t got, want;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
        i_stall <= quiet ? 1'b0 : ($urandom_range(99) < 38);
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_found, o_pixel_count, o_mean_x_q, o_mean_y_q, o_var_x_q, o_var_y_q,
                   o_cov_xy_q, o_area_q};
            if (expected_stats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result transaction: %p", got);
            end else begin
                want = expected_stats.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Mismatch: exp %p", want);
                        $display("          got %p", got);
                    end
                end
            end
        end
    end

    task automatic send_pixel(logic [PIX_W-1:0] pix);
        while (!quiet && $urandom_range(99) < 38) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel <= pix;
        do @(posedge i_clk); while (o_stall);
        accumulate_pixel(pix);
        pixels_sent++;
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_stats.size() != 0) @(posedge i_clk);
        // partial frames leave no result to wait on, so hold off the full latency
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        i_valid    <= 1'b0;
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_WIDTH) frame_w = val;
        else if (idx == REG_HEIGHT) frame_h = val;
    endtask

    task automatic set_size(int w, int h);
        write_reg(REG_WIDTH, w[CFG_W-1:0]);
        write_reg(REG_HEIGHT, h[CFG_W-1:0]);
    endtask

    function automatic logic [PIX_W-1:0] rand_pixel(int density);
        if ($urandom_range(99) < density) return PIX_W'($urandom_range(255, 1));
        return '0;
    endfunction

    task automatic test_single_pixel_frames();
        set_size(1, 1);
        send_pixel(8'h00);
        send_pixel(8'hFF);
        send_pixel(8'h01);
        send_pixel(8'h80);
        wait_idle();
        // zero size reads as one
        set_size(0, 0);
        send_pixel(8'h7F);
        send_pixel(8'h00);
        wait_idle();
    endtask

    task automatic test_shape_extremes();
        int f;
        set_size(2, 2);
        // anti-diagonal: negative covariance and zero determinant
        send_pixel(8'h00); send_pixel(8'h55);
        send_pixel(8'hAA); send_pixel(8'h00);
        // full square
        repeat (4) send_pixel(8'h01);
        // empty frame
        repeat (4) send_pixel(8'h00);
        wait_idle();
        // oversized width clamps to the maximum, one row
        set_size(2047, 1);
        f = frames_done;
        while (frames_done == f) send_pixel(rand_pixel(5));
        wait_idle();
        set_size(1, 200);
        f = frames_done;
        while (frames_done == f) send_pixel(rand_pixel(50));
        wait_idle();
        write_reg(REG_UNUSED, 11'h7FF);
    endtask

    task automatic test_resize_mid_frame();
        int f;
        set_size(4, 4);
        repeat (6) send_pixel(8'hC3);
        wait_idle();
        // column counter already past the new last column
        set_size(2, 3);
        f = frames_done;
        while (frames_done == f) send_pixel(8'h3C);
        wait_idle();
    endtask

    task automatic test_random_frames();
        int w, h, density, f, start;
        start = pixels_sent;
        while (pixels_sent - start < 500) begin
            if ($urandom_range(3) == 0) begin
                wait_idle();
                if ($urandom_range(9) == 0) begin
                    w = $urandom_range(32, 1); h = $urandom_range(32, 1);
                end else begin
                    w = $urandom_range(6, 1); h = $urandom_range(6, 1);
                end
                set_size(w, h);
            end
            quiet = (pixels_sent - start > 150) && (pixels_sent - start < 400);
            density = $urandom_range(100);
            f = frames_done;
            while (frames_done == f) send_pixel(rand_pixel(density));
        end
        quiet = 1'b0;
    endtask

    initial begin
        frame_w = WIDTH_RST; frame_h = HEIGHT_RST;
        clear_sums();
        frames_done = 0; pixels_sent = 0; mismatches = 0; cycles = 0; quiet = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_single_pixel_frames();
        test_shape_extremes();
        test_resize_mid_frame();
        test_random_frames();
        wait_idle();
        if (mismatches == 0 && expected_stats.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

// File: filelist.f
+incdir+rtl
rtl/bbm_pkg.sv
rtl/bbm_front.sv
rtl/bbm_queue.sv
rtl/bbm_arith.sv
rtl/bbm_back.sv
rtl/binary_blob_moments_core.sv
verif/binary_blob_moments_core_tb.sv
